// File: rtl/assert_macros.svh
// Assertion helpers shared by the RTL; clk and rst must be in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// cons must hold at every edge where ante holds
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// File: rtl/xll_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xll_pkg
// Types and codes shared by the XOR linked list engine and its channels.
// ----------------------------------------------------------------------------
package xll_pkg;

  localparam int OP_W     = 2;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int LEN_W    = 7;

  typedef enum logic [OP_W-1:0] {
    OP_SEARCH  = 2'd0,
    OP_INSERT  = 2'd1,
    OP_DELETE  = 2'd2,
    OP_REVERSE = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE   = 2'd0,
    ST_ABSENT = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_DEL_NEXT,
    S_INS_TAKE,
    S_INS_LINK
  } state_t;

  // free stack controls from the engine
  typedef struct packed {
    logic push;
    logic pop;
  } fs_ctrl_t;

endpackage

// File: rtl/xll_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xll_req_if
// Request channel: one operation and its operand per item.
// ----------------------------------------------------------------------------
interface xll_req_if;
  import xll_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           operation;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, operation, value, input ready);
  modport sink   (input valid, operation, value, output ready);
endinterface

// File: rtl/xll_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xll_rsp_if
// Response channel: match flag, status code and list length per item.
// ----------------------------------------------------------------------------
interface xll_rsp_if;
  import xll_pkg::*;

  logic                valid;
  logic                ready;
  logic                found;
  logic [STATUS_W-1:0] status;
  logic [LEN_W-1:0]    length;

  modport source (output valid, found, status, length, input ready);
  modport sink   (input valid, found, status, length, output ready);
endinterface

// File: rtl/xor_linked_list_engine.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// xor_linked_list_engine
// Doubly linked list of signed 32-bit values held as XOR links in a node pool.
// ----------------------------------------------------------------------------
// One request is handled at a time; a response waits in an output register
// and the next request is taken as soon as that register is free or being
// drained. Reverse, and search or delete on an empty list, are answered
// from the idle state. Insert pops the free stack and relinks the old head
// in S_INS_TAKE, then links the new node in S_INS_LINK; when the pool is
// full it is answered from the idle state with ST_FULL. Search and delete
// walk from the head over at most CAPACITY nodes: the walk reads value and
// link of one node per cycle from the node memories, and a delete with a
// successor goes on to S_DEL_NEXT to rewrite the successor's link.
// ----------------------------------------------------------------------------
module xor_linked_list_engine #(
  parameter int CAPACITY = 64
) (
  input  logic     clk,
  input  logic     rst,
  xll_req_if.sink   req,
  xll_rsp_if.source rsp
);
  import xll_pkg::*;

  localparam int IdxW = $clog2(CAPACITY + 1);

  state_t state, state_next;

  logic signed [VALUE_W-1:0] value_q, value_next;
  op_t             op_q, op_next;
  logic [IdxW-1:0] head, head_next;
  logic [IdxW-1:0] tail, tail_next;
  logic [IdxW-1:0] curr, curr_next;
  logic [IdxW-1:0] prev, prev_next;
  logic [IdxW-1:0] prev_link, prev_link_next;
  logic [IdxW-1:0] steps, steps_next;
  logic [IdxW-1:0] node, node_next;

  // node memories, index 0 unused
  logic signed [VALUE_W-1:0] value_mem [CAPACITY + 1];
  logic [IdxW-1:0]           link_mem  [CAPACITY + 1];
  logic signed [VALUE_W-1:0] rd_value;
  logic [IdxW-1:0]           rd_link;
  logic [IdxW-1:0]           rd_addr;
  logic                      val_we;
  logic [IdxW-1:0]           val_waddr;
  logic signed [VALUE_W-1:0] val_wdata;
  logic                      lnk_we;
  logic [IdxW-1:0]           lnk_waddr;
  logic [IdxW-1:0]           lnk_wdata;

  fs_ctrl_t        fs_ctrl;
  logic [IdxW-1:0] fs_top;
  logic [IdxW-1:0] fs_count;

  logic [IdxW-1:0] len;
  logic [IdxW-1:0] succ_raw;
  logic [IdxW-1:0] succ;
  logic [IdxW-1:0] steps_inc;

  logic                out_valid;
  logic                out_found;
  logic [STATUS_W-1:0] out_status;
  logic [LEN_W-1:0]    out_length;
  logic                out_load;
  logic                load_found;
  status_t             load_status;
  logic [IdxW-1:0]     load_len;

  xll_free_stack #(.CAPACITY(CAPACITY)) u_free_stack (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (fs_ctrl),
    .push_node (curr),
    .top       (fs_top),
    .count     (fs_count)
  );

  assign len       = IdxW'(CAPACITY) - fs_count;
  assign succ_raw  = prev ^ rd_link;
  assign succ      = (succ_raw > IdxW'(CAPACITY)) ? '0 : succ_raw;
  assign steps_inc = steps + 1'b1;

  always_ff @(posedge clk) begin
    if (val_we) begin
      value_mem[val_waddr] <= val_wdata;
    end
    rd_value <= value_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (lnk_we) begin
      link_mem[lnk_waddr] <= lnk_wdata;
    end
    rd_link <= link_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      tail  <= '0;
    end else begin
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
    end
  end

  always_ff @(posedge clk) begin
    value_q   <= value_next;
    op_q      <= op_next;
    curr      <= curr_next;
    prev      <= prev_next;
    prev_link <= prev_link_next;
    steps     <= steps_next;
    node      <= node_next;
  end

  always_comb begin
    state_next     = state;
    value_next     = value_q;
    op_next        = op_q;
    head_next      = head;
    tail_next      = tail;
    curr_next      = curr;
    prev_next      = prev;
    prev_link_next = prev_link;
    steps_next     = steps;
    node_next      = node;
    rd_addr        = head;
    val_we         = 1'b0;
    val_waddr      = node;
    val_wdata      = value_q;
    lnk_we         = 1'b0;
    lnk_waddr      = node;
    lnk_wdata      = head;
    fs_ctrl        = '0;
    out_load       = 1'b0;
    load_found     = 1'b0;
    load_status    = ST_DONE;
    load_len       = len;
    req.ready      = 1'b0;

    unique case (state)
      S_IDLE: begin
        req.ready = !rst && (!out_valid || rsp.ready);
        if (req.valid && req.ready) begin
          op_next    = op_t'(req.operation);
          value_next = req.value;
          unique case (op_t'(req.operation))
            OP_SEARCH, OP_DELETE: begin
              if (head == '0) begin
                out_load    = 1'b1;
                load_status = ST_ABSENT;
              end else begin
                curr_next  = head;
                prev_next  = '0;
                steps_next = '0;
                state_next = S_WALK;
              end
            end
            OP_INSERT: begin
              if (fs_count == '0) begin
                out_load    = 1'b1;
                load_status = ST_FULL;
              end else begin
                // link of the old head comes back with the stack top
                state_next = S_INS_TAKE;
              end
            end
            OP_REVERSE: begin
              head_next = tail;
              tail_next = head;
              out_load  = 1'b1;
            end
          endcase
        end
      end

      S_WALK: begin
        if (rd_value == value_q) begin
          if (op_q == OP_SEARCH) begin
            out_load   = 1'b1;
            load_found = 1'b1;
            state_next = S_IDLE;
          end else begin
            // unlink curr: predecessor now points past it
            if (prev != '0) begin
              lnk_we    = 1'b1;
              lnk_waddr = prev;
              lnk_wdata = prev_link ^ curr ^ succ;
            end else begin
              head_next = succ;
            end
            fs_ctrl.push = (len != '0);
            if (succ == '0) begin
              tail_next  = prev;
              out_load   = 1'b1;
              load_found = 1'b1;
              load_len   = (len != '0) ? len - 1'b1 : len;
              state_next = S_IDLE;
            end else begin
              rd_addr    = succ;
              node_next  = succ;
              state_next = S_DEL_NEXT;
            end
          end
        end else if (succ == '0 || steps_inc == IdxW'(CAPACITY)) begin
          out_load    = 1'b1;
          load_status = ST_ABSENT;
          state_next  = S_IDLE;
        end else begin
          // advance one node
          rd_addr        = succ;
          prev_next      = curr;
          prev_link_next = rd_link;
          curr_next      = succ;
          steps_next     = steps_inc;
        end
      end

      S_DEL_NEXT: begin
        lnk_we     = 1'b1;
        lnk_waddr  = node;
        lnk_wdata  = rd_link ^ curr ^ prev;
        out_load   = 1'b1;
        load_found = 1'b1;
        state_next = S_IDLE;
      end

      S_INS_TAKE: begin
        fs_ctrl.pop = 1'b1;
        node_next   = fs_top;
        val_we      = 1'b1;
        val_waddr   = fs_top;
        if (head != '0) begin
          lnk_we    = 1'b1;
          lnk_waddr = head;
          lnk_wdata = rd_link ^ fs_top;
        end
        state_next = S_INS_LINK;
      end

      S_INS_LINK: begin
        lnk_we    = 1'b1;
        lnk_waddr = node;
        lnk_wdata = head;
        head_next = node;
        if (head == '0) begin
          tail_next = node;
        end
        out_load   = 1'b1;
        state_next = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_found  <= load_found;
      out_status <= load_status;
      out_length <= LEN_W'(load_len);
    end
  end

  assign rsp.valid  = out_valid;
  assign rsp.found  = out_found;
  assign rsp.status = out_status;
  assign rsp.length = out_length;

  `ASSERT_IMPLY(a_load_free, out_load, !out_valid || rsp.ready, "response overwritten")
  `ASSERT_IMPLY(a_empty_consistent, state != S_INS_LINK,
    (head == '0) == (fs_count == IdxW'(CAPACITY)), "head and free count disagree")
  `ASSERT_IMPLY(a_walk_bound, state == S_WALK, steps < IdxW'(CAPACITY), "walk past pool size")
endmodule

// File: rtl/xll_free_stack.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// xll_free_stack
// Stack of free node indices in a synchronous memory. Entries below the
// lowest depth ever reached still hold their reset contents, which are
// generated rather than stored.
// ----------------------------------------------------------------------------
module xll_free_stack #(
  parameter int CAPACITY = 64,
  localparam int IdxW    = $clog2(CAPACITY + 1),
  localparam int PosW    = $clog2(CAPACITY)
) (
  input  logic             clk,
  input  logic             rst,
  input  xll_pkg::fs_ctrl_t ctrl,
  input  logic [IdxW-1:0]  push_node,
  output logic [IdxW-1:0]  top,
  output logic [IdxW-1:0]  count
);
  import xll_pkg::*;

  logic [IdxW-1:0] stack_mem [CAPACITY];
  logic [IdxW-1:0] rd_node;
  logic [IdxW-1:0] pos;
  logic [IdxW-1:0] low_mark;

  // top of stack, read every cycle from the current depth
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      stack_mem[count[PosW-1:0]] <= push_node;
    end
    rd_node <= stack_mem[PosW'(count - 1'b1)];
    pos     <= count - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= IdxW'(CAPACITY);
      low_mark <= IdxW'(CAPACITY);
    end else if (ctrl.push) begin
      count <= count + 1'b1;
    end else if (ctrl.pop) begin
      count <= count - 1'b1;
      if ((count - 1'b1) < low_mark) begin
        low_mark <= count - 1'b1;
      end
    end
  end

  // never written since reset: reset contents count down from CAPACITY
  assign top = (pos < low_mark) ? (IdxW'(CAPACITY) - pos) : rd_node;

  `ASSERT_ALWAYS(a_fs_one_op, !(ctrl.push && ctrl.pop), "push and pop together")
  `ASSERT_IMPLY(a_fs_no_overflow, ctrl.push, count != IdxW'(CAPACITY), "push onto full stack")
  `ASSERT_IMPLY(a_fs_no_underflow, ctrl.pop, count != '0, "pop from empty stack")
  `ASSERT_ALWAYS(a_fs_mark, low_mark <= count, "low mark above depth")
endmodule
